FILE: sv/gfp_pkg.sv
// Package: shared types, register indexes, sequencer steps and constants for the GPS fix block.
package gfp_pkg;

    typedef struct packed {
        logic signed [30:0] fix_lat;
        logic signed [31:0] fix_lon;
        logic signed [27:0] fix_alt;
        logic        [31:0] fix_time;
        logic               fix_present;
    } t_fix;

    typedef struct packed {
        logic signed [39:0] pos_north;
        logic signed [39:0] pos_east;
        logic signed [39:0] pos_up;
        logic signed [31:0] vel_north;
        logic signed [31:0] vel_east;
        logic signed [31:0] vel_up;
        logic               fix_available;
        logic               same_time;
    } t_res;

    typedef struct packed {
        logic [2:0]  index;
        logic [31:0] value;
    } t_cfg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MLOAD,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } t_state;

    localparam logic [2:0] CFG_HOME_LAT   = 3'd0;
    localparam logic [2:0] CFG_HOME_LON   = 3'd1;
    localparam logic [2:0] CFG_HOME_ALT   = 3'd2;
    localparam logic [2:0] CFG_HOME_TIME  = 3'd3;
    localparam logic [2:0] CFG_TIME_SCALE = 3'd4;

    localparam logic [4:0] SP_DLAT  = 5'd0;
    localparam logic [4:0] SP_DLON  = 5'd1;
    localparam logic [4:0] SP_X     = 5'd2;
    localparam logic [4:0] SP_X2    = 5'd3;
    localparam logic [4:0] SP_NORTH = 5'd4;
    localparam logic [4:0] SP_E1    = 5'd5;
    localparam logic [4:0] SP_H7    = 5'd6;
    localparam logic [4:0] SP_H1    = 5'd12;
    localparam logic [4:0] SP_EAST  = 5'd13;
    localparam logic [4:0] SP_VN    = 5'd14;
    localparam logic [4:0] SP_VE    = 5'd15;
    localparam logic [4:0] SP_VU    = 5'd16;

    localparam logic [26:0] PI180_Q32       = 27'd74961321;
    localparam logic [33:0] EARTH_RADIUS_MM = 34'd6371000000;
    localparam logic [30:0] DEG90_Q23       = 31'd754974720;
    localparam logic [30:0] DEG180_Q23      = 31'd1509949440;
    localparam logic [30:0] ONE_Q30         = 31'h40000000;
    localparam logic [9:0]  TIME_SCALE_RST  = 10'd1000;
    localparam logic [5:0]  MUL_STEPS       = 6'd40;
    localparam logic [6:0]  DIV_STEPS       = 7'd64;

    // ceil(2^42 / ((2k)(2k-1))): exact floor division of a 34-bit value by multiply and >> 42
    function automatic logic [41:0] horner_recip(input logic [2:0] k);
        logic [41:0] m;
        case (k)
            3'd7:    m = 42'd24165090721;
            3'd6:    m = 42'd33318534176;
            3'd5:    m = 42'd48867183457;
            3'd4:    m = 42'd78536544842;
            3'd3:    m = 42'd146601550371;
            3'd2:    m = 42'd366503875926;
            3'd1:    m = 42'd2199023255552;
            default: m = 42'd0;
        endcase
        return m;
    endfunction

endpackage

FILE: sv/gfp_if.sv
// Interfaces: fix request, result request and register write channels.
interface gfp_fix_if;
    import gfp_pkg::*;
    logic valid;
    logic ready;
    t_fix data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface gfp_res_if;
    import gfp_pkg::*;
    logic valid;
    logic ready;
    t_res data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface gfp_cfg_if;
    import gfp_pkg::*;
    logic valid;
    logic ready;
    t_cfg data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: sv/gps_fix_to_local_position_speed_top.sv
// Top level: GPS fix to local north/east/up position and speed, shared serial multiply/divide.
//
//  channel  | dir | payload                                   | handshake
//  i_fix    | in  | fix_lat, fix_lon, fix_alt, fix_time, pres | valid/ready
//  o_res    | out | pos_*, vel_*, fix_available, same_time    | valid/ready
//  i_cfg    | in  | index, value                              | valid/ready
//
// A request with no fix or a repeated timestamp is answered the cycle after acceptance.
// Other requests run 24 passes of a 40-step shift-add multiplier (two per cosine term, the
// second a reciprocal multiply) and 3 passes of a 64-step restoring divider.
// Reset (synchronous, active low) clears the sequencer, track state and home registers and sets the time scale to 1000.
// A new fix is taken only when idle, the previous result has been taken and no register
// write is offered.
module gps_fix_to_local_position_speed_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gfp_fix_if.sink    i_fix,
    gfp_res_if.source  o_res,
    gfp_cfg_if.sink    i_cfg
);
    import gfp_pkg::*;

    t_state r_state, n_state;
    logic [4:0] r_step;

    logic signed [30:0] r_home_lat;
    logic signed [31:0] r_home_lon;
    logic signed [27:0] r_home_alt;
    logic [9:0]         r_ts;
    logic signed [39:0] r_prev_n, r_prev_e, r_prev_u;
    logic [31:0]        r_prev_time;

    logic signed [30:0] r_lat;
    logic signed [31:0] r_lon;
    logic signed [27:0] r_alt;
    logic [31:0]        r_time;
    logic signed [32:0] r_dt;

    logic signed [34:0] r_rad_n, r_rad_e, r_t;
    logic [31:0]        r_x;
    logic [32:0]        r_x2;
    logic               r_cneg;
    logic signed [39:0] r_n, r_e;
    logic [39:0]        r_e1;
    logic signed [31:0] r_vn, r_ve;
    logic [33:0]        r_hn;
    logic               r_hsub;

    logic [87:0] r_acc, r_ma;
    logic [39:0] r_mb;
    logic [5:0]  r_mcnt;

    logic [40:0] r_rem;
    logic [63:0] r_quo;
    logic [39:0] r_dvs;
    logic [6:0]  r_dcnt;
    logic        r_dneg;

    t_res r_res;
    logic r_ovalid;

    logic               w_acc_fix, w_acc_cfg, w_mdone, w_ddone, w_horner, w_vel;
    logic signed [32:0] w_dt_in;
    logic signed [31:0] w_dlat;
    logic signed [32:0] w_dlon;
    logic [31:0]        w_mdlat;
    logic [32:0]        w_mdlon;
    logic [30:0]        w_alat, w_ared;
    logic               w_cneg;
    logic [33:0]        w_r;
    logic [34:0]        w_mrad_n, w_mrad_e, w_mt;
    logic [30:0]        w_cmag;
    logic signed [41:0] w_dn, w_de, w_du;
    logic signed [28:0] w_u;
    logic signed [41:0] w_dsel;
    logic [40:0]        w_mdsel;
    logic [32:0]        w_mdt;
    logic [47:0]        w_opa;
    logic [39:0]        w_opb;
    logic [58:0]        w_rnd25;
    logic [69:0]        w_rnd30;
    logic [40:0]        w_rsh, w_rsub;
    logic               w_rge;
    logic [34:0]        w_q35;
    logic signed [34:0] w_tnew;
    logic signed [31:0] w_vsat;
    logic [2:0]         w_k;

    assign w_acc_fix = i_fix.valid && i_fix.ready;
    assign w_acc_cfg = i_cfg.valid && i_cfg.ready;
    assign i_fix.ready = (r_state == ST_IDLE) && !r_ovalid && !i_cfg.valid;
    assign i_cfg.ready = (r_state == ST_IDLE);
    assign o_res.valid = r_ovalid;
    assign o_res.data  = r_res;

    assign w_mdone  = (r_mcnt == MUL_STEPS);
    assign w_ddone  = (r_dcnt == DIV_STEPS);
    assign w_horner = (r_step >= SP_H7) && (r_step <= SP_H1);
    assign w_vel    = (r_step >= SP_VN);
    assign w_k      = 3'(5'd13 - r_step);

    assign w_dt_in = $signed({1'b0, i_fix.data.fix_time}) - $signed({1'b0, r_prev_time});

    assign w_dlat  = $signed({r_lat[30], r_lat}) - $signed({r_home_lat[30], r_home_lat});
    assign w_dlon  = $signed({r_lon[31], r_lon}) - $signed({r_home_lon[31], r_home_lon});
    assign w_mdlat = w_dlat[31] ? 32'(-w_dlat) : 32'(w_dlat);
    assign w_mdlon = w_dlon[32] ? 33'(-w_dlon) : 33'(w_dlon);
    assign w_alat  = r_lat[30] ? 31'(-r_lat) : 31'(r_lat);
    assign w_cneg  = (w_alat > DEG90_Q23);
    assign w_ared  = w_cneg ? (DEG180_Q23 - w_alat) : w_alat;
    assign w_r     = EARTH_RADIUS_MM + 34'(signed'(r_alt));
    assign w_mrad_n = r_rad_n[34] ? 35'(-r_rad_n) : 35'(r_rad_n);
    assign w_mrad_e = r_rad_e[34] ? 35'(-r_rad_e) : 35'(r_rad_e);
    assign w_mt     = r_t[34] ? 35'(-r_t) : 35'(r_t);
    assign w_cmag   = r_t[34] ? 31'd0 :
                      (r_t > $signed({4'b0, ONE_Q30})) ? ONE_Q30 : r_t[30:0];

    assign w_u  = $signed({r_alt[27], r_alt}) - $signed({r_home_alt[27], r_home_alt});
    assign w_dn = 42'(r_n) - 42'(r_prev_n);
    assign w_de = 42'(r_e) - 42'(r_prev_e);
    assign w_du = 42'(w_u) - 42'(r_prev_u);

    always_comb begin
        case (r_step)
            SP_VN:   w_dsel = w_dn;
            SP_VE:   w_dsel = w_de;
            default: w_dsel = w_du;
        endcase
    end
    assign w_mdsel = w_dsel[41] ? 41'(-w_dsel) : 41'(w_dsel);
    assign w_mdt   = r_dt[32] ? 33'(-r_dt) : 33'(r_dt);

    always_comb begin
        w_opa = '0;
        w_opb = '0;
        case (r_step)
            SP_DLAT: begin
                w_opa = 48'(w_mdlat);
                w_opb = 40'(PI180_Q32);
            end
            SP_DLON: begin
                w_opa = 48'(w_mdlon);
                w_opb = 40'(PI180_Q32);
            end
            SP_X: begin
                w_opa = 48'(w_ared);
                w_opb = 40'(PI180_Q32);
            end
            SP_X2: begin
                w_opa = 48'(r_x);
                w_opb = 40'(r_x);
            end
            SP_NORTH: begin
                w_opa = 48'(w_r);
                w_opb = 40'(w_mrad_n);
            end
            SP_E1: begin
                w_opa = 48'(w_r);
                w_opb = 40'(w_mrad_e);
            end
            SP_EAST: begin
                w_opa = 48'(r_e1);
                w_opb = 40'(w_cmag);
            end
            default: begin
                if (w_horner && r_hsub) begin
                    w_opa = 48'(horner_recip(w_k));
                    w_opb = 40'(r_hn);
                end else if (w_horner) begin
                    w_opa = 48'(r_x2);
                    w_opb = 40'(w_mt);
                end else begin
                    w_opa = 48'(w_mdsel);
                    w_opb = 40'(r_ts);
                end
            end
        endcase
    end

    assign w_rnd25 = r_acc[58:0] + 59'h1000000;
    assign w_rnd30 = r_acc[69:0] + 70'h20000000;

    assign w_rsh  = {r_rem[39:0], r_quo[63]};
    assign w_rge  = (w_rsh >= {1'b0, r_dvs});
    assign w_rsub = w_rsh - {1'b0, r_dvs};

    assign w_q35  = {1'b0, r_acc[75:42]};
    assign w_tnew = $signed({4'b0, ONE_Q30}) - (r_t[34] ? 35'(-w_q35) : 35'(w_q35));

    always_comb begin
        if (!r_dneg && (r_quo > 64'h7FFFFFFF)) begin
            w_vsat = 32'sh7FFFFFFF;
        end else if (r_dneg && (r_quo > 64'h80000000)) begin
            w_vsat = 32'sh80000000;
        end else begin
            w_vsat = r_dneg ? 32'(-r_quo[31:0]) : 32'(r_quo[31:0]);
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_acc_fix && i_fix.data.fix_present && (w_dt_in != '0)) begin
                    n_state = ST_MLOAD;
                end
            end
            ST_MLOAD: n_state = ST_MUL;
            ST_MUL: begin
                if (w_mdone) begin
                    n_state = w_vel ? ST_DIV : ST_MLOAD;
                end
            end
            ST_DIV: begin
                if (w_ddone) begin
                    n_state = (r_step == SP_VU) ? ST_DONE : ST_MLOAD;
                end
            end
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= '0;
            r_hsub      <= 1'b0;
            r_home_lat  <= '0;
            r_home_lon  <= '0;
            r_home_alt  <= '0;
            r_ts        <= TIME_SCALE_RST;
            r_prev_n    <= '0;
            r_prev_e    <= '0;
            r_prev_u    <= '0;
            r_prev_time <= '0;
            r_ovalid    <= 1'b0;
            r_mcnt      <= '0;
            r_dcnt      <= '0;
        end else begin
            if (r_ovalid && o_res.ready) begin
                r_ovalid <= 1'b0;
            end
            if (w_acc_cfg) begin
                case (i_cfg.data.index)
                    CFG_HOME_LAT: r_home_lat <= i_cfg.data.value[30:0];
                    CFG_HOME_LON: r_home_lon <= i_cfg.data.value;
                    CFG_HOME_ALT: r_home_alt <= i_cfg.data.value[27:0];
                    CFG_HOME_TIME: begin
                        r_prev_time <= i_cfg.data.value;
                        r_prev_n    <= '0;
                        r_prev_e    <= '0;
                        r_prev_u    <= '0;
                    end
                    CFG_TIME_SCALE: r_ts <= i_cfg.data.value[9:0];
                    default: ;
                endcase
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_acc_fix) begin
                        r_lat  <= i_fix.data.fix_lat;
                        r_lon  <= i_fix.data.fix_lon;
                        r_alt  <= i_fix.data.fix_alt;
                        r_time <= i_fix.data.fix_time;
                        r_dt   <= w_dt_in;
                        r_step <= SP_DLAT;
                        r_hsub <= 1'b0;
                        r_t    <= $signed({4'b0, ONE_Q30});
                        if (!i_fix.data.fix_present) begin
                            r_res    <= '0;
                            r_ovalid <= 1'b1;
                        end else if (w_dt_in == '0) begin
                            r_res <= '{pos_north: r_prev_n, pos_east: r_prev_e,
                                       pos_up: r_prev_u, vel_north: '0, vel_east: '0,
                                       vel_up: '0, fix_available: 1'b1, same_time: 1'b1};
                            r_ovalid <= 1'b1;
                        end
                    end
                end
                ST_MLOAD: begin
                    r_ma   <= 88'(w_opa);
                    r_mb   <= w_opb;
                    r_acc  <= '0;
                    r_mcnt <= '0;
                end
                ST_MUL: begin
                    if (!w_mdone) begin
                        if (r_mb[0]) begin
                            r_acc <= r_acc + r_ma;
                        end
                        r_ma   <= {r_ma[86:0], 1'b0};
                        r_mb   <= {1'b0, r_mb[39:1]};
                        r_mcnt <= r_mcnt + 6'd1;
                    end else if (w_vel) begin
                        r_rem  <= '0;
                        r_quo  <= r_acc[63:0];
                        r_dvs  <= 40'(w_mdt);
                        r_dneg <= w_dsel[41] ^ r_dt[32];
                        r_dcnt <= '0;
                    end else if (w_horner && !r_hsub) begin
                        r_hn   <= r_acc[63:30];
                        r_hsub <= 1'b1;
                    end else begin
                        r_step <= r_step + 5'd1;
                        r_hsub <= 1'b0;
                        case (r_step)
                            SP_DLAT: r_rad_n <= w_dlat[31] ? -$signed({1'b0, w_rnd25[58:25]})
                                                          : $signed({1'b0, w_rnd25[58:25]});
                            SP_DLON: r_rad_e <= w_dlon[32] ? -$signed({1'b0, w_rnd25[58:25]})
                                                          : $signed({1'b0, w_rnd25[58:25]});
                            SP_X: begin
                                r_x    <= w_rnd25[56:25];
                                r_cneg <= w_cneg;
                            end
                            SP_X2:    r_x2 <= r_acc[62:30];
                            SP_NORTH: r_n  <= r_rad_n[34] ? -$signed({1'b0, w_rnd30[68:30]})
                                                          : $signed({1'b0, w_rnd30[68:30]});
                            SP_E1:    r_e1 <= w_rnd30[69:30];
                            SP_EAST:  r_e  <= (r_rad_e[34] ^ r_cneg)
                                              ? -$signed({1'b0, w_rnd30[68:30]})
                                              : $signed({1'b0, w_rnd30[68:30]});
                            default:  r_t  <= w_tnew;
                        endcase
                    end
                end
                ST_DIV: begin
                    if (!w_ddone) begin
                        r_rem  <= w_rge ? w_rsub : w_rsh;
                        r_quo  <= {r_quo[62:0], w_rge};
                        r_dcnt <= r_dcnt + 7'd1;
                    end else begin
                        r_step <= r_step + 5'd1;
                        case (r_step)
                            SP_VN:   r_vn <= w_vsat;
                            SP_VE:   r_ve <= w_vsat;
                            SP_VU: begin
                                r_res <= '{pos_north: r_n, pos_east: r_e, pos_up: 40'(w_u),
                                           vel_north: r_vn, vel_east: r_ve, vel_up: w_vsat,
                                           fix_available: 1'b1, same_time: 1'b0};
                            end
                            default: ;
                        endcase
                    end
                end
                ST_DONE: begin
                    r_prev_n    <= r_n;
                    r_prev_e    <= r_e;
                    r_prev_u    <= 40'(w_u);
                    r_prev_time <= r_time;
                    r_ovalid    <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !i_fix.ready)
        else $error("fix taken while sequencer busy");

    a_mul_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL) |-> (r_mcnt <= MUL_STEPS))
        else $error("multiplier step count overrun");

    a_done_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |=> r_ovalid)
        else $error("finished request not presented");

    a_same_avail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_res.same_time) |-> r_res.fix_available)
        else $error("repeated time without fix");

    a_nofix_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !r_res.fix_available) |-> (r_res.vel_north == '0 && r_res.pos_north == '0))
        else $error("no-fix result carries data");

endmodule
